[rtl/b64sd_pkg.sv]
`default_nettype none
package b64sd_pkg;

	// Width of the per-message byte counter.
	localparam int COUNT_BITS = 16;
	// Width used when the counter is compared against the 16-bit capacity.
	localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

	// Capacity register after reset.
	localparam logic [15:0] CAP_RESET = 16'd64;

	// Output queue geometry (depth is a power of two).
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);

	// Status codes, also used as the held error.
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_RESOURCE = 2'd2
	} status_t;

	// One decoded character.
	typedef struct packed {
		logic       valid;
		logic [5:0] value;
	} digit_t;

	// One result word as queued for the output channel.
	typedef struct packed {
		logic        is_status;
		logic [7:0]  data_byte;
		status_t     status_code;
		logic [15:0] byte_total;
		logic        out_last;
	} result_t;

endpackage
`default_nettype wire

[rtl/b64sd_digit.sv]
`default_nettype none
module b64sd_digit (
	input  wire logic [7:0]        ch,
	output b64sd_pkg::digit_t      digit
);
	import b64sd_pkg::*;

	// Map the base64url alphabet onto six-bit digits; anything else is flagged.
	always_comb begin
		digit.valid = 1'b1;
		digit.value = 6'd0;
		if (ch >= 8'h41 && ch <= 8'h5A) begin
			digit.value = 6'(ch - 8'h41);
		end else if (ch >= 8'h61 && ch <= 8'h7A) begin
			digit.value = 6'(ch - 8'h61 + 8'd26);
		end else if (ch >= 8'h30 && ch <= 8'h39) begin
			digit.value = 6'(ch - 8'h30 + 8'd52);
		end else if (ch == 8'h2D) begin
			digit.value = 6'd62;
		end else if (ch == 8'h5F) begin
			digit.value = 6'd63;
		end else begin
			digit.valid = 1'b0;
		end
	end

endmodule
`default_nettype wire

[rtl/base64url_strict_decoder_top.sv]
`default_nettype none
// Channel   Handshake              Payload
// input     in_valid / in_ready    in_char, in_last
// output    out_valid / out_ready  is_status, data_byte, status_code, byte_total, out_last
// config    cfg_wr_en              cfg_wr_data (output capacity)
//
// One character is accepted per cycle while in_ready is high; it passes through the input
// register and its results then enter a four-word output queue, so each word is registered
// twice on its way out. A final character that completes a byte queues two words, which the
// consumer takes one at a time. Input is held off only while the queue has fewer than two free
// places. Reset clears the message state and sets capacity to 64.
module base64url_strict_decoder_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  in_char,
	input  wire logic        in_last,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             is_status,
	output logic [7:0]       data_byte,
	output logic [1:0]       status_code,
	output logic [15:0]      byte_total,
	output logic             out_last,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data
);
	import b64sd_pkg::*;

	logic                  valid_s1;
	logic [7:0]            char_s1;
	logic                  last_s1;
	logic [15:0]           cap_q;
	logic [11:0]           acc_q;
	logic [2:0]            pend_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [1:0]            phase_q;
	status_t               err_q;
	result_t               fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0]      head_q;
	logic [PTR_W-1:0]      tail_q;
	logic [FCNT_W-1:0]     fcnt_q;
	digit_t                digit;
	logic                  fire;
	logic                  pop;
	logic [11:0]           acc_sh;
	logic [3:0]            pend_sum;
	logic [2:0]            pend_left;
	logic                  full_cap;
	logic                  emit;
	logic [7:0]            byte_val;
	logic [11:0]           acc_n;
	logic [2:0]            pend_n;
	logic [COUNT_BITS-1:0] cnt_n;
	status_t               err_n;
	status_t               code;
	result_t               res_data;
	result_t               res_stat;
	logic [1:0]            n_push;

	b64sd_digit u_digit (
		.ch    (char_s1),
		.digit (digit)
	);

	// Queue handshake; a character moves on only with room for two words.
	assign fire      = valid_s1 && (fcnt_q <= FCNT_W'(FIFO_DEPTH - 2));
	assign in_ready  = !valid_s1 || fire;
	assign out_valid = (fcnt_q != '0);
	assign pop       = out_valid && out_ready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= in_char;
			last_s1 <= in_last;
		end
	end

	// Shift the new digit in and see whether a byte completes.
	always_comb begin
		acc_sh    = {acc_q[5:0], digit.value};
		pend_sum  = {1'b0, pend_q} + 4'd6;
		pend_left = 3'(pend_sum - 4'd8);
		full_cap  = (CMP_W'(cnt_q) >= CMP_W'(cap_q)) || (&cnt_q);
		byte_val  = 8'(acc_sh >> pend_left);
		emit      = 1'b0;
		acc_n     = acc_q;
		pend_n    = pend_q;
		cnt_n     = cnt_q;
		err_n     = err_q;
		if (err_q == ST_OK) begin
			if (!digit.valid) begin
				err_n = ST_INVALID;
			end else if (pend_sum >= 4'd8) begin
				pend_n = pend_left;
				if (full_cap) begin
					err_n = ST_RESOURCE;
					acc_n = acc_sh;
				end else begin
					emit  = 1'b1;
					cnt_n = cnt_q + 1'b1;
					acc_n = acc_sh & ((12'd1 << pend_left) - 12'd1);
				end
			end else begin
				pend_n = pend_sum[2:0];
				acc_n  = acc_sh;
			end
		end
	end

	// Closing status for the final character, the data word and the number of words to queue.
	always_comb begin
		if (phase_q == 2'd0) begin
			code = ST_INVALID;
		end else if (err_n != ST_OK) begin
			code = err_n;
		end else if (pend_n != 3'd0 && acc_n != 12'd0) begin
			code = ST_INVALID;
		end else begin
			code = ST_OK;
		end
		res_stat.is_status   = 1'b1;
		res_stat.data_byte   = 8'd0;
		res_stat.status_code = code;
		res_stat.byte_total  = (code == ST_OK) ? 16'(CMP_W'(cnt_n)) : 16'd0;
		res_stat.out_last    = 1'b1;
		res_data.is_status   = 1'b0;
		res_data.data_byte   = byte_val;
		res_data.status_code = ST_OK;
		res_data.byte_total  = 16'd0;
		res_data.out_last    = 1'b0;
		n_push = fire ? ({1'b0, emit} + {1'b0, last_s1}) : 2'd0;
	end

	// Message state and capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			acc_q   <= '0;
			pend_q  <= '0;
			cnt_q   <= '0;
			phase_q <= '0;
			err_q   <= ST_OK;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (fire) begin
				if (last_s1) begin
					acc_q   <= '0;
					pend_q  <= '0;
					cnt_q   <= '0;
					phase_q <= '0;
					err_q   <= ST_OK;
				end else begin
					acc_q   <= acc_n;
					pend_q  <= pend_n;
					cnt_q   <= cnt_n;
					phase_q <= phase_q + 2'd1;
					err_q   <= err_n;
				end
			end
		end
	end

	// Output queue storage: the data word goes first, the status after it.
	always_ff @(posedge clk) begin
		if (fire) begin
			if (emit) begin
				fifo_q[tail_q] <= res_data;
				if (last_s1) begin
					fifo_q[tail_q + PTR_W'(1)] <= res_stat;
				end
			end else if (last_s1) begin
				fifo_q[tail_q] <= res_stat;
			end
		end
	end

	// Output queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fcnt_q <= '0;
		end else begin
			tail_q <= tail_q + PTR_W'(n_push);
			if (pop) begin
				head_q <= head_q + PTR_W'(1);
			end
			fcnt_q <= fcnt_q + FCNT_W'(n_push) - FCNT_W'(pop);
		end
	end

	assign is_status   = fifo_q[head_q].is_status;
	assign data_byte   = fifo_q[head_q].data_byte;
	assign status_code = fifo_q[head_q].status_code;
	assign byte_total  = fifo_q[head_q].byte_total;
	assign out_last    = fifo_q[head_q].out_last;

	// The queue never holds more words than it has places.
	assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= FCNT_W'(FIFO_DEPTH))
		else $error("output queue overfilled");

	// A final character leaves the message state cleared.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_s1 |=> (phase_q == 2'd0) && (cnt_q == '0) && (err_q == ST_OK))
		else $error("message state not cleared after status");

	// Every word shown marks the message end exactly when it is a status.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_status == out_last))
		else $error("status and last flags disagree");

	// Input is held off only behind a waiting character.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && !fire)
		else $error("input stalled without cause");

endmodule
`default_nettype wire
